[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[rtl/ppte_pkg.sv]
package ppte_pkg;

   localparam int ColW             = 18;
   localparam int FillW            = 7;
   localparam int RowPixW          = 16;
   localparam int CsrDataW         = 18;
   localparam int TextLineUnits    = 68;
   localparam int BilevelLineUnits = 64;
   localparam int SampleUnits      = 4;
   localparam int BilevelUnits     = 16;
   localparam int MaxChars         = 18;
   localparam int StepW            = 5;
   localparam int QueueDepth       = 2;

   localparam logic [7:0] AsciiZero  = 8'h30;
   localparam logic [7:0] AsciiSpace = 8'h20;
   localparam logic [7:0] AsciiCr    = 8'h0D;
   localparam logic [7:0] AsciiLf    = 8'h0A;

   typedef enum logic [1:0] {
      CSR_BILEVEL_MODE = 2'd0,
      CSR_ROW_PIXELS   = 2'd1,
      CSR_ROW_SAMPLES  = 2'd2
   } csr_index_type;

   // One classified input byte, as handed from front to back.
   typedef struct packed {
      logic       bilevel;
      logic [7:0] pixel_byte;
      logic [3:0] pixel_count;   // 1..8 pixels in bilevel mode
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] ones;
      logic       line_break;    // CR LF follows the body
   } item_type;

   typedef struct packed {
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] ones;
   } digits_type;

   // Decimal split of a byte without a divider: compares for hundreds,
   // reciprocal multiply (205 / 2048) for tens, exact below 100.
   function automatic digits_type to_digits(input logic [7:0] v);
      digits_type  d;
      logic [7:0]  rem;
      logic [14:0] prod;
      logic [6:0]  tens_x10;
      d.hund = (v >= 8'd200) ? 4'd2 : ((v >= 8'd100) ? 4'd1 : 4'd0);
      rem = v - ((v >= 8'd200) ? 8'd200 : ((v >= 8'd100) ? 8'd100 : 8'd0));
      prod = 15'(rem[6:0]) * 15'd205;
      d.tens = prod[14:11];
      tens_x10 = {d.tens[3:0], 3'b000} + {2'b00, d.tens[3:0], 1'b0};
      d.ones = 4'(rem[6:0] - tens_x10);
      return d;
   endfunction

endpackage

[rtl/plain_pnm_text_encoder.sv]
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  pixel_byte
// rsp_      out        rsp_valid/rsp_stall  text_char, last_of_run
// csr_      in         csr_write_enable     csr_index, csr_write_data
//
// With an item queued and rsp_stall low, one character leaves per cycle; a byte-mode
// sample gives 4 or 6 characters and a bilevel byte 2 to 18 (2 per pixel, plus 2 for
// CR LF), set by the character sequencer. The front takes a byte whenever the two-entry
// queue has room. Synchronous reset clears the counters, the queue and rsp_valid.
// rsp_stall holds the output register; the front keeps accepting until the queue fills.
module plain_pnm_text_encoder
   import ppte_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [CsrDataW-1:0] csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_pixel_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_text_char,
   output logic                rsp_last_of_run
);

   logic     accept;
   logic     queue_full;
   logic     pop;
   logic     head_valid;
   item_type new_item;
   item_type head_item;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   ppte_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .accept          (accept),
      .pixel_byte      (req_pixel_byte),
      .item            (new_item)
   );

   ppte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (new_item),
      .full      (queue_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_item (head_item)
   );

   ppte_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_text_char  (rsp_text_char),
      .rsp_last_of_run(rsp_last_of_run)
   );

endmodule

[rtl/ppte_front.sv]
module ppte_front
   import ppte_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [CsrDataW-1:0] csr_write_data,
   input  logic                accept,
   input  logic [7:0]          pixel_byte,
   output item_type            item
);

   logic               bilevel_mode_ff;
   logic [RowPixW-1:0] row_pixels_ff;
   logic [ColW-1:0]    row_samples_ff;
   logic [ColW-1:0]    column_count_ff;
   logic [ColW-1:0]    column_count_in;
   logic [FillW-1:0]   line_fill_ff;
   logic [FillW-1:0]   line_fill_in;

   logic [ColW:0]      col_plus1;
   logic [ColW:0]      pix_left;
   logic [3:0]         pixel_count;
   logic [ColW:0]      col_next;
   logic [FillW:0]     fill_next;
   logic               row_end;
   logic               line_full;
   digits_type         digits;

   always_ff @(posedge clock) begin
      if (reset) begin
         bilevel_mode_ff <= 1'b0;
         row_pixels_ff   <= RowPixW'(1);
         row_samples_ff  <= ColW'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BILEVEL_MODE: bilevel_mode_ff <= csr_write_data[0];
            CSR_ROW_PIXELS:   row_pixels_ff   <= csr_write_data[RowPixW-1:0];
            CSR_ROW_SAMPLES:  row_samples_ff  <= csr_write_data[ColW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      col_plus1 = {1'b0, column_count_ff} + (ColW+1)'(1);
      pix_left  = (ColW+1)'(row_pixels_ff) - {1'b0, column_count_ff};
      // the MSB pixel is always written, even past the row end
      if ((ColW+1)'(row_pixels_ff) <= col_plus1) begin
         pixel_count = 4'd1;
      end else if (pix_left >= (ColW+1)'(8)) begin
         pixel_count = 4'd8;
      end else begin
         pixel_count = pix_left[3:0];
      end

      if (bilevel_mode_ff) begin
         col_next  = {1'b0, column_count_ff} + (ColW+1)'(pixel_count);
         row_end   = col_next >= (ColW+1)'(row_pixels_ff);
         fill_next = {1'b0, line_fill_ff} + (FillW+1)'(BilevelUnits);
         line_full = fill_next >= (FillW+1)'(BilevelLineUnits);
      end else begin
         col_next  = col_plus1;
         row_end   = col_next >= {1'b0, row_samples_ff};
         fill_next = {1'b0, line_fill_ff} + (FillW+1)'(SampleUnits);
         line_full = fill_next >= (FillW+1)'(TextLineUnits);
      end

      column_count_in = row_end ? '0 : col_next[ColW-1:0];
      line_fill_in    = (row_end || line_full) ? '0 : fill_next[FillW-1:0];

      digits           = to_digits(pixel_byte);
      item.bilevel     = bilevel_mode_ff;
      item.pixel_byte  = pixel_byte;
      item.pixel_count = pixel_count;
      item.hund        = digits.hund;
      item.tens        = digits.tens;
      item.ones        = digits.ones;
      item.line_break  = row_end || line_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         line_fill_ff    <= '0;
      end else if (accept) begin
         column_count_ff <= column_count_in;
         line_fill_ff    <= line_fill_in;
      end
   end

endmodule

[rtl/ppte_queue.sv]
`include "assert_macros.svh"

module ppte_queue
   import ppte_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item
);

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   item_type        slot_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   assign full       = count_ff == CntW'(QueueDepth);
   assign head_valid = count_ff != '0;
   assign head_item  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

   `ASSERT_CLK(a_no_overflow, full |-> !push, "push into a full queue")
   `ASSERT_CLK(a_no_underflow, !head_valid |-> !pop, "pop from an empty queue")
   `ASSERT_CLK(a_count_bound, count_ff <= CntW'(QueueDepth), "queue count out of range")

endmodule

[rtl/ppte_back.sv]
`include "assert_macros.svh"

module ppte_back
   import ppte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  item_type   head_item,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_text_char,
   output logic       rsp_last_of_run
);

   logic [StepW-1:0] step_ff;
   logic [StepW-1:0] step_in;
   logic             rsp_valid_ff;
   logic [7:0]       text_char_ff;
   logic [7:0]       text_char_in;
   logic             last_ff;
   logic             last_in;
   logic             advance;
   logic [StepW-1:0] body_len;
   logic [StepW-1:0] total_len;
   logic [2:0]       bit_sel;

   assign advance = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop     = advance && last_in;

   always_comb begin
      body_len  = head_item.bilevel ? {head_item.pixel_count, 1'b0} : StepW'(4);
      total_len = body_len + (head_item.line_break ? StepW'(2) : StepW'(0));
      last_in   = step_ff == total_len - StepW'(1);
      step_in   = last_in ? '0 : step_ff + StepW'(1);
      bit_sel   = 3'd7 - step_ff[3:1];

      if (step_ff == body_len) begin
         text_char_in = AsciiCr;
      end else if (step_ff > body_len) begin
         text_char_in = AsciiLf;
      end else if (head_item.bilevel) begin
         text_char_in = step_ff[0] ? AsciiSpace
                                   : (AsciiZero | 8'(head_item.pixel_byte[bit_sel]));
      end else begin
         case (step_ff[1:0])
            2'd0: text_char_in = (head_item.hund != '0)
                                 ? (AsciiZero | 8'(head_item.hund)) : AsciiSpace;
            2'd1: text_char_in = (head_item.hund != '0 || head_item.tens != '0)
                                 ? (AsciiZero | 8'(head_item.tens)) : AsciiSpace;
            2'd2: text_char_in = AsciiZero | 8'(head_item.ones);
            default: text_char_in = AsciiSpace;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         step_ff      <= step_in;
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         text_char_ff <= text_char_in;
         last_ff      <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_text_char   = text_char_ff;
   assign rsp_last_of_run = last_ff;

   `ASSERT_CLK(a_step_bound, step_ff < StepW'(MaxChars), "character step past item length")
   `ASSERT_CLK(a_step_idle, !head_valid |-> step_ff == '0, "step left open with no item")

endmodule
